### src/mos_pkg.sv
// ----------------------------------------------------------------------------
// mos_pkg
// Shared command and status types of the sample-set median block.
// ----------------------------------------------------------------------------
package mos_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MEDIAN_W = 17;
	localparam int USED_W   = 7;

	// commands from the controller to the datapath, at most one set per cycle
	typedef struct packed {
		logic cap;      // take the input beat, start an insertion
		logic rd_prev;  // read the entry below the insertion point
		logic shift;    // move the entry read up one place, step down
		logic put;      // write the sample at the insertion point
		logic med_rd;   // read the middle entries
		logic med_out;  // load the result register, end the set
	} dp_cmd_t;

	typedef struct packed {
		logic full;      // store holds its capacity
		logic pos_zero;  // insertion point at the bottom
		logic pos_one;   // insertion point one above the bottom
		logic gt;        // entry read is greater than the sample
		logic last;      // sample in hand closes the set
	} dp_status_t;

endpackage

### src/mos_datapath.sv
// ----------------------------------------------------------------------------
// mos_datapath
// Ordered sample store, insertion point, count, drop flag and result register.
// ----------------------------------------------------------------------------
module mos_datapath #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mos_pkg::dp_cmd_t                cmd,
	output mos_pkg::dp_status_t             status,
	input  logic signed [mos_pkg::SAMPLE_W-1:0] sample,
	input  logic                            last_sample,
	output logic signed [mos_pkg::MEDIAN_W-1:0] median_value,
	output logic        [mos_pkg::USED_W-1:0]   samples_used,
	output logic                            overflowed
);
	import mos_pkg::*;

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

	logic signed [SAMPLE_W-1:0] s_q;
	logic signed [SAMPLE_W-1:0] rdata_a_q;
	logic signed [SAMPLE_W-1:0] rdata_b_q;
	logic                       last_q;
	logic [AW-1:0]              pos_q;
	logic [CW-1:0]              count_q;
	logic                       drop_q;
	logic signed [MEDIAN_W-1:0] median_q;
	logic [USED_W-1:0]          used_q;
	logic                       ovf_q;

	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic signed [SAMPLE_W-1:0] wr_data;
	logic                       rd_en_a;
	logic [AW-1:0]              rd_addr_a;
	logic [AW-1:0]              rd_addr_b;
	logic [CW-1:0]              half;
	logic [AW-1:0]              half_addr;
	logic [CW+USED_W-1:0]       count_ext;
	logic signed [MEDIAN_W-1:0] mid_sum;

	always_comb begin
		half      = count_q >> 1;
		half_addr = half[AW-1:0];
		wr_en     = cmd.shift | cmd.put;
		wr_addr   = pos_q;
		wr_data   = cmd.shift ? rdata_a_q : s_q;
		rd_en_a   = cmd.rd_prev | cmd.shift | cmd.med_rd;
		rd_addr_b = half_addr;
		if (cmd.rd_prev) begin
			rd_addr_a = pos_q - AW'(1);
		end else if (cmd.shift) begin
			rd_addr_a = pos_q - AW'(2);
		end else if (count_q[0]) begin
			// odd count: both ports on the middle, the sum doubles it
			rd_addr_a = half_addr;
		end else begin
			rd_addr_a = half_addr - AW'(1);
		end
		count_ext = {{USED_W{1'b0}}, count_q};
		mid_sum   = {rdata_a_q[SAMPLE_W-1], rdata_a_q} + {rdata_b_q[SAMPLE_W-1], rdata_b_q};
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en_a) begin
			rdata_a_q <= mem[rd_addr_a];
		end
		if (cmd.med_rd) begin
			rdata_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			s_q    <= sample;
			last_q <= last_sample;
			pos_q  <= count_q[AW-1:0];
		end else if (cmd.shift) begin
			pos_q <= pos_q - AW'(1);
		end
		if (cmd.med_out) begin
			median_q <= mid_sum;
			used_q   <= count_ext[USED_W-1:0];
			ovf_q    <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.med_out) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			if (cmd.put) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.cap && status.full) begin
				drop_q <= 1'b1;
			end
		end
	end

	always_comb begin
		status.full     = (count_q == CW'(MAX_SAMPLES));
		status.pos_zero = (pos_q == '0);
		status.pos_one  = (pos_q == AW'(1));
		status.gt       = (rdata_a_q > s_q);
		status.last     = last_q;
	end

	assign median_value = median_q;
	assign samples_used = used_q;
	assign overflowed   = ovf_q;

endmodule

### src/mos_ctrl.sv
// ----------------------------------------------------------------------------
// mos_ctrl
// Sequencer for insertion into the ordered store and for the median read-out.
// ----------------------------------------------------------------------------
module mos_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output mos_pkg::dp_cmd_t    cmd,
	input  mos_pkg::dp_status_t status
);
	import mos_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_PUT,
		ST_MED_RD,
		ST_MED_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:    cmd.cap = in_valid;
			ST_READ: begin
				// nothing is written or read for a dropped sample
				cmd.put     = status.pos_zero && !status.full;
				cmd.rd_prev = !status.pos_zero && !status.full;
			end
			ST_CMP: begin
				cmd.shift = status.gt;
				cmd.put   = !status.gt;
			end
			ST_PUT:     cmd.put = 1'b1;
			ST_MED_RD:  cmd.med_rd = 1'b1;
			ST_MED_OUT: cmd.med_out = out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// a full store drops the sample, only the median may follow
					if (status.full) begin
						state_q <= status.last ? ST_MED_RD : ST_IDLE;
					end else if (status.pos_zero) begin
						state_q <= status.last ? ST_MED_RD : ST_IDLE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (!status.gt) begin
						state_q <= status.last ? ST_MED_RD : ST_IDLE;
					end else if (status.pos_one) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					state_q <= status.last ? ST_MED_RD : ST_IDLE;
				end
				ST_MED_RD: begin
					state_q <= ST_MED_OUT;
				end
				ST_MED_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### src/median_of_sample_set_top.sv
// ----------------------------------------------------------------------------
// median_of_sample_set_top
// Median of a set of signed Q8.8 samples, result in signed Q8.9.
// ----------------------------------------------------------------------------
// Input channel: one sample per beat on in_valid/in_stall, last_sample marks
// the final beat of a set. Output channel: one result beat per set on
// out_valid/out_stall with median_value, samples_used and overflowed.
// Each sample is placed into an ascending store by walking down from the top
// one entry a cycle, each step reading the next entry down while writing the
// entry read before one place up. A sample that goes to the bottom of an
// empty store is written without a walk, and one that finds the store full
// is dropped without a walk. After the last sample, the sequencer reads the
// middle entries and then loads the result register. in_stall is high whenever
// the sequencer is not idle. Samples beyond MAX_SAMPLES are dropped and flagged.
// Reset clears the sample count, the drop flag and the output valid; store
// contents are not cleared, entries are only read once written. If the
// receiver stalls, the result holds and the block may still take the next
// set; the following result waits until the register is free.
// ----------------------------------------------------------------------------
module median_of_sample_set_top #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [mos_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [mos_pkg::MEDIAN_W-1:0] median_value,
	output logic        [mos_pkg::USED_W-1:0]   samples_used,
	output logic                                overflowed
);
	import mos_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	mos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	mos_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample),
		.last_sample  (last_sample),
		.median_value (median_value),
		.samples_used (samples_used),
		.overflowed   (overflowed)
	);

endmodule

### bench/median_sb_pkg.sv
// ----------------------------------------------------------------------------
// median_sb_pkg
// Result prediction and checking for the sample-set median block.
// ----------------------------------------------------------------------------
// Keeps its own ascending copy of the samples of the set in progress. Each
// accepted input beat is inserted in order, or dropped once the store holds
// its capacity. On the closing beat it works out the median in Q8.9 and
// queues it. Result beats are checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
package median_sb_pkg;

	import mos_pkg::*;

	localparam int STORE_DEPTH = 64;

	typedef struct {
		logic signed [MEDIAN_W-1:0] median;
		logic        [USED_W-1:0]   used;
		logic                       dropped;
	} median_result_t;

	class median_scoreboard;
		logic signed [SAMPLE_W-1:0] held[STORE_DEPTH];
		int unsigned                held_n;
		bit                         dropped;
		median_result_t             awaited[$];
		int unsigned                errors;

		function new();
			held_n  = 0;
			dropped = 1'b0;
			errors  = 0;
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] s, logic closes);
			int unsigned    pos;
			int unsigned    half;
			int             mid;
			median_result_t r;
			if (held_n < STORE_DEPTH) begin
				// equal samples stay below the newcomer
				pos = held_n;
				while (pos > 0 && held[pos-1] > s) begin
					held[pos] = held[pos-1];
					pos--;
				end
				held[pos] = s;
				held_n++;
			end else begin
				dropped = 1'b1;
			end
			if (closes) begin
				half = held_n / 2;
				// q8.9 result: twice the middle, or the plain sum of the two middles
				if ((held_n % 2) != 0)
					mid = 2 * int'(held[half]);
				else
					mid = int'(held[half-1]) + int'(held[half]);
				r.median  = mid[MEDIAN_W-1:0];
				r.used    = held_n[USED_W-1:0];
				r.dropped = dropped;
				awaited.push_back(r);
				held_n  = 0;
				dropped = 1'b0;
			end
		endfunction

		function void check_result(logic signed [MEDIAN_W-1:0] m, logic [USED_W-1:0] u,
				logic o);
			median_result_t e;
			if (awaited.size() == 0) begin
				$error("result beat with nothing awaited: median_value %0d", m);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (m !== e.median) begin
				$error("median_value: expected %0d, actual %0d", e.median, m);
				errors++;
			end
			if (u !== e.used) begin
				$error("samples_used: expected %0d, actual %0d", e.used, u);
				errors++;
			end
			if (o !== e.dropped) begin
				$error("overflowed: expected %0d, actual %0d", e.dropped, o);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

endpackage

### bench/median_of_sample_set_top_tb.sv
// ----------------------------------------------------------------------------
// median_of_sample_set_top_tb
// Self-checking bench for the sample-set median block.
// ----------------------------------------------------------------------------
// A short directed run covers the sample extremes, odd and even counts, equal
// and reversed samples. Random sets follow, mostly short with a few that fill
// the store exactly or spill past it, under three idling patterns on both
// channels. One stretch holds off the result side long enough for the block
// to back up onto its input. Every result beat is checked against the
// scoreboard's prediction; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module median_of_sample_set_top_tb;

	import mos_pkg::*;
	import median_sb_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam int LONG_HOLD    = 400;
	localparam int PHASE_BEATS  = 170;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample      = '0;
	logic                       last_sample = 1'b0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic signed [MEDIAN_W-1:0] median_value;
	logic        [USED_W-1:0]   samples_used;
	logic                       overflowed;

	median_scoreboard sb;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_asks    = 0;
	int hold_done    = 0;
	int hold_left    = 0;
	int quiet        = 0;

	median_of_sample_set_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.last_sample (last_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.median_value(median_value),
		.samples_used(samples_used),
		.overflowed  (overflowed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: random stalls, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_done != hold_asks) begin
			hold_done++;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	// beat monitors and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_sample(sample, last_sample);
			if (out_valid && !out_stall)
				sb.check_result(median_value, samples_used, overflowed);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 16'sh7FFF;
		else if (r < 16)
			return 16'sh8000;
		else if (r < 40)
			return SAMPLE_W'($urandom_range(0, 8) - 4); // near zero, many repeats
		else
			return SAMPLE_W'($urandom_range(0, 65535));
	endfunction

	task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input logic closes);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < snd_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample      <= s;
		last_sample <= closes;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++)
			send_beat(pick_sample(), i == n - 1);
	endtask

	// stop offering beats until every awaited result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int beats, input int first_len);
		int sent;
		int n;
		int k;
		send_set(first_len);
		sent = first_len;
		while (sent < beats) begin
			k = $urandom_range(0, 99);
			if (k < 80)
				n = $urandom_range(1, 12);
			else if (k < 92)
				n = $urandom_range(13, 40);
			else
				n = $urandom_range(60, 70);
			send_set(n);
			sent += n;
		end
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		snd_idle_pct = 38;
		rcv_idle_pct <= 60;
		@(posedge clk);

		// single samples at both extremes
		send_beat(16'sh7FFF, 1'b1);
		send_beat(16'sh8000, 1'b1);
		// pairs at the extremes
		send_beat(16'sh7FFF, 1'b0);
		send_beat(16'sh8000, 1'b1);
		send_beat(16'sh8000, 1'b0);
		send_beat(16'sh8000, 1'b1);
		send_beat(16'sh7FFF, 1'b0);
		send_beat(16'sh7FFF, 1'b1);
		// equal samples
		send_beat(16'sh0005, 1'b0);
		send_beat(16'sh0005, 1'b0);
		send_beat(16'sh0005, 1'b1);
		// descending, each one goes to the bottom
		send_beat(16'sh0003, 1'b0);
		send_beat(16'sh0002, 1'b0);
		send_beat(16'sh0001, 1'b0);
		send_beat(16'sh0000, 1'b1);
		// ascending across zero
		send_beat(16'shFFFF, 1'b0);
		send_beat(16'sh0000, 1'b0);
		send_beat(16'sh0001, 1'b0);
		send_beat(16'sh0002, 1'b0);
		send_beat(16'sh0003, 1'b1);
		send_beat(16'sh0000, 1'b1);
		drain();

		// store filled exactly by the first set
		random_phase(PHASE_BEATS, STORE_DEPTH);

		// long hold-off on the result side while sets keep coming
		hold_asks <= hold_asks + 1;
		snd_idle_pct = 0;
		repeat (5) send_set($urandom_range(1, 4));
		drain();

		snd_idle_pct = 60;
		rcv_idle_pct <= 38;
		// closing beat dropped on a full store
		random_phase(PHASE_BEATS, STORE_DEPTH + 1);
		drain();

		snd_idle_pct = 0;
		rcv_idle_pct <= 0;
		random_phase(PHASE_BEATS, STORE_DEPTH + 2);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
